FILE: rtl/ghtab_pkg.sv
// Shared operation codes, status codes and handle layout for the generational handle table.
package ghtab_pkg;

    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 16;
    localparam int SLOT_W   = 16;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_NOT_LIVE = 2'd2;

endpackage

FILE: rtl/generational_handle_table_top.sv
// Top level of the generational handle table (slot map) with its control sequencer.
//
// The table hands out 32-bit handles: the low 16 bits name a slot and the high 16 bits carry
// the slot's generation, which advances by one on every add and wraps at 2^16. Live objects
// are kept packed in a dense array, and every result beat reports the dense position and the
// live count after the operation. Each input beat yields exactly one result beat. The block
// works on one operation at a time and holds in_stall high until the result has been placed
// in the output register; a result waiting there does not keep the next beat out. After the
// accepting edge, an add, a lookup or a remove of a dead handle whose slot lies inside the
// table passes through S_EVAL and then S_EMIT; a remove of a live handle passes through
// S_EVAL, S_FIX, S_LINK and S_EMIT; an add on a full table, a slot number at or above
// CAPACITY or the unused operation code goes straight to S_EMIT. S_EMIT waits while the
// previous result still sits in the output register under out_stall. The next beat is taken
// once the sequencer is back in S_IDLE. These paths come from the read-modify-write sequence
// on the slot memory, which has one write port and a registered read: a remove rewrites its
// own slot, then the slot of the entry that moves into the vacated dense position, then the
// link of the free list tail. The slot memory is never cleared. Slots are allocated in
// ascending order until every slot has been used once, and a fill count separates those
// slots from the ones that still hold their reset state, so the block is ready right after
// reset. Freed slots are reused oldest first.
module generational_handle_table_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ghtab_pkg::op_t             operation,
    input  logic [31:0]                handle_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ghtab_pkg::status_t         status,
    output logic [31:0]                handle_out,
    output logic [9:0]                 dense_position,
    output logic [10:0]                live_total
);

    import ghtab_pkg::*;

    // SW indexes a slot or a dense position; CW holds a count from zero to CAPACITY.
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // One slot memory word: live flag, generation, dense position and free list link.
    // The slot number part of the stored handle always equals the address, so it is not kept.
    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
        logic [SW-1:0]    dpos;
        logic [SW-1:0]    link;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FIX,
        S_LINK,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [31:0]    hnd_reg, hnd_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic           fresh_hit_reg, fresh_hit_next;
    logic [CW-1:0]  live_reg, live_next;
    logic [CW-1:0]  fresh_reg, fresh_next;
    logic [SW-1:0]  rhead_reg, rhead_next;
    logic [SW-1:0]  rtail_reg, rtail_next;
    logic [SW-1:0]  pos_reg, pos_next;
    logic [SW-1:0]  ls_reg, ls_next;
    logic           link_reg, link_next;
    status_t        res_status_reg, res_status_next;
    logic [31:0]    res_handle_reg, res_handle_next;
    logic [SW-1:0]  res_pos_reg, res_pos_next;

    logic           out_valid_reg, out_valid_next;
    status_t        status_reg, status_next;
    logic [31:0]    handle_out_reg, handle_out_next;
    logic [9:0]     dense_position_reg, dense_position_next;
    logic [10:0]    live_total_reg, live_total_next;

    // Memory ports.
    logic              slot_we;
    logic [SW-1:0]     slot_waddr;
    slot_entry_t       slot_wdata;
    logic [SW-1:0]     slot_raddr;
    logic [ENTRY_W-1:0] slot_rdata_raw;
    slot_entry_t       slot_rdata;
    logic              dense_we;
    logic [SW-1:0]     dense_waddr;
    logic [SW-1:0]     dense_wdata;
    logic [SW-1:0]     dense_raddr;
    logic [SW-1:0]     dense_rdata;

    // Helper values.
    logic [15:0]    in_slot;
    logic           in_range;
    logic           in_fresh_hit;
    logic           table_full;
    logic           alloc_fresh;
    logic [CW-1:0]  live_minus_one;
    slot_entry_t    entry;
    logic           handle_live;
    logic [GEN_W-1:0] gen_new;
    logic           out_free;
    logic [31:0]    pos_wide;
    logic [31:0]    live_wide;

    ghtab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata_raw)
    );

    ghtab_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    assign slot_rdata = slot_entry_t'(slot_rdata_raw);

    assign in_slot        = handle_in[15:0];
    assign in_range       = 32'(in_slot) < 32'(CAPACITY);
    assign in_fresh_hit   = 32'(in_slot) >= 32'(fresh_reg);
    assign table_full     = live_reg == CW'(CAPACITY);
    assign alloc_fresh    = fresh_reg != CW'(CAPACITY);
    assign live_minus_one = live_reg - CW'(1);

    // A slot at or above the fill count still holds its reset state: not live, generation zero.
    always_comb
    begin
        if (fresh_hit_reg)
        begin
            entry = '0;
        end
        else
        begin
            entry = slot_rdata;
        end
    end

    assign handle_live = entry.live && (entry.gen == hnd_reg[31:16]);
    assign gen_new     = entry.gen + GEN_W'(1);
    assign out_free    = !out_valid_reg || !out_stall;
    assign pos_wide    = 32'(res_pos_reg);
    assign live_wide   = 32'(live_reg);

    always_comb
    begin
        state_next          = state_reg;
        op_next             = op_reg;
        hnd_next            = hnd_reg;
        slot_next           = slot_reg;
        fresh_hit_next      = fresh_hit_reg;
        live_next           = live_reg;
        fresh_next          = fresh_reg;
        rhead_next          = rhead_reg;
        rtail_next          = rtail_reg;
        pos_next            = pos_reg;
        ls_next             = ls_reg;
        link_next           = link_reg;
        res_status_next     = res_status_reg;
        res_handle_next     = res_handle_reg;
        res_pos_next        = res_pos_reg;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        handle_out_next     = handle_out_reg;
        dense_position_next = dense_position_reg;
        live_total_next     = live_total_reg;

        slot_we     = 1'b0;
        slot_waddr  = slot_reg;
        slot_wdata  = entry;
        slot_raddr  = slot_reg;
        dense_we    = 1'b0;
        dense_waddr = live_reg[SW-1:0];
        dense_wdata = slot_reg;
        dense_raddr = live_minus_one[SW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // The dense read always targets the last live entry for a possible remove.
                if (in_valid)
                begin
                    op_next         = operation;
                    hnd_next        = handle_in;
                    res_handle_next = handle_in;
                    res_pos_next    = '0;
                    res_status_next = ST_NOT_LIVE;
                    state_next      = S_EMIT;
                    unique case (operation)
                        OP_ADD:
                        begin
                            if (table_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                slot_raddr     = rhead_reg;
                                fresh_hit_next = alloc_fresh;
                                slot_next      = alloc_fresh ? fresh_reg[SW-1:0] : rhead_reg;
                                state_next     = S_EVAL;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP:
                        begin
                            if (in_range)
                            begin
                                slot_raddr     = in_slot[SW-1:0];
                                slot_next      = in_slot[SW-1:0];
                                fresh_hit_next = in_fresh_hit;
                                state_next     = S_EVAL;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_EVAL:
            begin
                state_next = S_EMIT;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        slot_we          = 1'b1;
                        slot_wdata.live  = 1'b1;
                        slot_wdata.gen   = gen_new;
                        slot_wdata.dpos  = live_reg[SW-1:0];
                        dense_we         = 1'b1;
                        if (fresh_hit_reg)
                        begin
                            fresh_next = fresh_reg + CW'(1);
                        end
                        else
                        begin
                            rhead_next = entry.link;
                        end
                        live_next       = live_reg + CW'(1);
                        res_status_next = ST_OK;
                        res_handle_next = {gen_new, 16'(slot_reg)};
                        res_pos_next    = live_reg[SW-1:0];
                    end
                    OP_LOOKUP:
                    begin
                        if (handle_live)
                        begin
                            res_status_next = ST_OK;
                            res_pos_next    = entry.dpos;
                        end
                    end
                    default:
                    begin
                        // Remove: retire the slot and move the last dense entry into the hole.
                        if (handle_live)
                        begin
                            slot_we         = 1'b1;
                            slot_wdata.live = 1'b0;
                            dense_we        = 1'b1;
                            dense_waddr     = entry.dpos;
                            dense_wdata     = dense_rdata;
                            slot_raddr      = dense_rdata;
                            pos_next        = entry.dpos;
                            ls_next         = dense_rdata;
                            link_next       = fresh_reg != live_reg;
                            live_next       = live_minus_one;
                            res_status_next = ST_OK;
                            state_next      = S_FIX;
                        end
                    end
                endcase
            end

            S_FIX:
            begin
                // When the removed entry was the last one, its slot is already up to date.
                slot_raddr = rtail_reg;
                slot_waddr = ls_reg;
                slot_wdata = slot_rdata;
                slot_wdata.dpos = pos_reg;
                slot_we    = ls_reg != slot_reg;
                state_next = S_LINK;
            end

            S_LINK:
            begin
                slot_waddr      = rtail_reg;
                slot_wdata      = slot_rdata;
                slot_wdata.link = slot_reg;
                if (link_reg)
                begin
                    slot_we = 1'b1;
                end
                else
                begin
                    rhead_next = slot_reg;
                end
                rtail_next = slot_reg;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    handle_out_next     = res_handle_reg;
                    dense_position_next = pos_wide[9:0];
                    live_total_next     = live_wide[10:0];
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= OP_ADD;
            hnd_reg            <= '0;
            slot_reg           <= '0;
            fresh_hit_reg      <= 1'b0;
            live_reg           <= '0;
            fresh_reg          <= '0;
            rhead_reg          <= '0;
            rtail_reg          <= '0;
            pos_reg            <= '0;
            ls_reg             <= '0;
            link_reg           <= 1'b0;
            res_status_reg     <= ST_OK;
            res_handle_reg     <= '0;
            res_pos_reg        <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= ST_OK;
            handle_out_reg     <= '0;
            dense_position_reg <= '0;
            live_total_reg     <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            op_reg             <= op_next;
            hnd_reg            <= hnd_next;
            slot_reg           <= slot_next;
            fresh_hit_reg      <= fresh_hit_next;
            live_reg           <= live_next;
            fresh_reg          <= fresh_next;
            rhead_reg          <= rhead_next;
            rtail_reg          <= rtail_next;
            pos_reg            <= pos_next;
            ls_reg             <= ls_next;
            link_reg           <= link_next;
            res_status_reg     <= res_status_next;
            res_handle_reg     <= res_handle_next;
            res_pos_reg        <= res_pos_next;
            out_valid_reg      <= out_valid_next;
            status_reg         <= status_next;
            handle_out_reg     <= handle_out_next;
            dense_position_reg <= dense_position_next;
            live_total_reg     <= live_total_next;
        end
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign handle_out     = handle_out_reg;
    assign dense_position = dense_position_reg;
    assign live_total     = live_total_reg;

endmodule

FILE: rtl/ghtab_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ghtab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ghtab_checker.sv
// Port-level checker for the generational handle table and its bind to the top level.
module ghtab_checker #(
    parameter int CAPACITY = 1024
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ghtab_pkg::op_t     operation,
    input logic [31:0]        handle_in,
    input logic               out_valid,
    input logic               out_stall,
    input ghtab_pkg::status_t status,
    input logic [31:0]        handle_out,
    input logic [9:0]         dense_position,
    input logic [10:0]        live_total
);

    import ghtab_pkg::*;

    // A result beat held by the receiver keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(handle_out)
            && $stable(dense_position) && $stable(live_total))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time, so it is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while the previous beat was still in flight");

    // A full report only comes with every slot live.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> live_total == 11'(CAPACITY))
        else $error("table full reported below capacity");

    // Failed operations report dense position zero.
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> dense_position == 10'd0)
        else $error("failed operation reported a dense position");

    // Consecutive result beats differ in the live count by at most one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && $changed(live_total) |->
            (live_total == $past(live_total) + 11'd1)
            || (live_total == $past(live_total) - 11'd1))
        else $error("live count moved by more than one");

endmodule

bind generational_handle_table_top ghtab_checker #(
    .CAPACITY (CAPACITY)
) u_ghtab_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .handle_in      (handle_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .handle_out     (handle_out),
    .dense_position (dense_position),
    .live_total     (live_total)
);
